/* rtl/core/ttw_pkg.sv */
// Shared types, constants and helpers for the text-mode terminal writer.
`timescale 1ns / 1ps

package ttw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Fixed widths of the cursor and cell fields on the ports.
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;
	localparam int CLR_W  = 4;

	localparam logic [7:0] NEWLINE_CODE   = 8'd10;
	localparam logic [7:0] BLANK_CODE     = 8'h20;
	localparam logic [7:0] LAST_PRINTABLE = 8'd126;

	localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
	localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

	typedef enum logic [2:0] {
		REQ_PUT    = 3'd0,
		REQ_CLEAR  = 3'd1,
		REQ_SCROLL = 3'd2,
		REQ_CURSOR = 3'd3,
		REQ_READ   = 3'd4
	} req_t;

	typedef enum logic [0:0] {
		CFG_FG = 1'b0,
		CFG_BG = 1'b1
	} cfg_idx_t;

	// Start of a sweep over the whole screen. A line count of zero blanks every
	// cell; otherwise rows move up by that many lines and the bottom is blanked.
	typedef struct packed {
		logic             start;
		logic [ROW_W-1:0] lines;
	} walk_cmd_t;

	function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] code,
		input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
		make_cell = {bg, fg, code};
	endfunction

endpackage

/* rtl/core/ttw_screen.sv */
// Screen cell memory with its read and write ports and the scroll and clear sweeper.
`timescale 1ns / 1ps

module ttw_screen
	import ttw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	localparam int CELLS  = ROWS * COLUMNS,
	localparam int AW     = $clog2(CELLS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CELL_W-1:0] blank_cell,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CELL_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CELL_W-1:0] rd_data,
	input  walk_cmd_t         walk_cmd,
	output logic              walk_done
);

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rd_data_q;

	logic          walking_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] offset_q;
	logic [AW-1:0] copy_end_q;

	logic          wv_s1;
	logic [AW-1:0] widx_s1;
	logic          copy_s1;

	logic              copy_now;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic [AW-1:0]     start_offset;

	assign start_offset = AW'(walk_cmd.lines) * AW'(COLUMNS);
	assign copy_now     = walking_q && (idx_q < copy_end_q);

	// Reads run ahead of writes by the scroll offset plus one entry and always
	// sit at higher addresses, so a copy never picks up a cell it has already moved.
	always_comb begin
		mem_re = rd_en;
		mem_ra = rd_addr;
		if (walking_q) begin
			mem_re = copy_now;
			mem_ra = AW'({1'b0, idx_q} + {1'b0, offset_q});
		end
		mem_we = wr_en;
		mem_wa = wr_addr;
		mem_wd = wr_data;
		if (wv_s1) begin
			mem_we = 1'b1;
			mem_wa = widx_s1;
			mem_wd = copy_s1 ? rd_data_q : blank_cell;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
			idx_q     <= '0;
			wv_s1     <= 1'b0;
		end else begin
			wv_s1 <= walking_q;
			if (walk_cmd.start) begin
				walking_q <= 1'b1;
				idx_q     <= '0;
			end else if (walking_q) begin
				idx_q <= idx_q + AW'(1);
				if (idx_q == LAST_CELL) begin
					walking_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		widx_s1 <= idx_q;
		copy_s1 <= copy_now;
		if (walk_cmd.start) begin
			offset_q   <= start_offset;
			copy_end_q <= (walk_cmd.lines == '0) ? '0 : AW'(CELLS) - start_offset;
		end
	end

	assign rd_data   = rd_data_q;
	assign walk_done = wv_s1 && (widx_s1 == LAST_CELL);

endmodule

/* rtl/core/text_mode_terminal_writer.sv */
// Top level of the text-mode terminal writer: request decode, cursor and result port.
//
// Requests arrive as beats on the slave stream (s_tvalid, s_tready, s_tdata); each
// beat yields exactly one result beat on the master stream (m_tvalid, m_tready,
// m_tdata) carrying status, the cursor after the request, the wrap flag and, for a
// read, the addressed cell. Colors are set through the write port (cfg_we,
// cfg_index, cfg_wdata); the user must set them only while no request is in flight;
// the block itself does not enforce it. One request is worked at a time. Put
// character, set cursor and rejected requests pass from accept to the done state
// and then to the output register; read cell passes through the read state first,
// as the cell memory read is registered. Clear, a nonzero scroll and a put character
// that runs past the bottom row sweep the whole cell memory, one cell per cycle.
// A finished result sits in the output register; the next request is taken while
// it waits, and that request holds its own result until the master side drains.
// Reset clears the cursor, the wrap flag and the handshakes and loads the default
// colors (foreground 7, background 0). Cell contents are not reset: a cell reads
// as valid only once a clear, scroll or character write has covered it.
`timescale 1ns / 1ps

module text_mode_terminal_writer
	import ttw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// req_type[2:0], char_code[10:3], scroll_lines[18:11], row[26:19], column[34:27]
	input  logic [39:0]      s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status[0], cursor_row[5:1], cursor_col[12:6], line_full[13], cell_word[29:14]
	output logic [31:0]      m_tdata,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CLR_W-1:0] cfg_wdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_WALK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_word;
		logic              line_full;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              status;
	} result_t;

	state_t state_q;
	state_t state_d;

	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	logic             wrap_q;
	logic [CLR_W-1:0] fg_q;
	logic [CLR_W-1:0] bg_q;

	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	// Request fields.
	req_t       in_req;
	logic [7:0] in_char;
	logic [7:0] in_lines;
	logic [7:0] in_row;
	logic [7:0] in_col;

	logic accept;
	logic pos_ok;
	logic out_free;

	// Decode results.
	logic             status_d;
	logic [ROW_W-1:0] row_d;
	logic [COL_W-1:0] col_d;
	logic             wrap_d;
	logic             walk_d;
	logic [ROW_W-1:0] walk_lines_d;
	logic             read_d;
	logic             put_we;

	logic [AW-1:0]     cursor_addr;
	logic [AW-1:0]     in_addr;
	logic [CELL_W-1:0] blank_cell;
	logic [CELL_W-1:0] rd_data;
	logic              walk_done;
	walk_cmd_t         walk_cmd;

	assign in_req   = req_t'(s_tdata[2:0]);
	assign in_char  = s_tdata[10:3];
	assign in_lines = s_tdata[18:11];
	assign in_row   = s_tdata[26:19];
	assign in_col   = s_tdata[34:27];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign pos_ok   = (in_row < 8'(ROWS)) && (in_col < 8'(COLUMNS));

	assign cursor_addr = AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q);
	assign in_addr     = AW'(in_row[ROW_W-1:0]) * AW'(COLUMNS) + AW'(in_col[COL_W-1:0]);
	assign blank_cell  = make_cell(BLANK_CODE, fg_q, bg_q);

	// Request decode. Cursor and wrap flag take their new values at the accept
	// edge; any memory work that the request needs follows from there.
	always_comb begin
		status_d     = 1'b0;
		row_d        = cur_row_q;
		col_d        = cur_col_q;
		wrap_d       = wrap_q;
		walk_d       = 1'b0;
		walk_lines_d = '0;
		read_d       = 1'b0;
		put_we       = 1'b0;
		case (in_req)
			REQ_PUT: begin
				if (in_char == NEWLINE_CODE) begin
					wrap_d = 1'b0;
					// A newline right after a line wrapped on its own is swallowed.
					if (!wrap_q) begin
						col_d = '0;
						if (cur_row_q == ROW_W'(ROWS - 1)) begin
							walk_d       = 1'b1;
							walk_lines_d = ROW_W'(1);
						end else begin
							row_d = cur_row_q + ROW_W'(1);
						end
					end
				end else begin
					wrap_d = 1'b0;
					if (!(in_char inside {[BLANK_CODE:LAST_PRINTABLE]})) begin
						status_d = 1'b1;
					end else begin
						put_we = 1'b1;
						if (cur_col_q == COL_W'(COLUMNS - 1)) begin
							wrap_d = 1'b1;
							col_d  = '0;
							if (cur_row_q == ROW_W'(ROWS - 1)) begin
								walk_d       = 1'b1;
								walk_lines_d = ROW_W'(1);
							end else begin
								row_d = cur_row_q + ROW_W'(1);
							end
						end else begin
							col_d = cur_col_q + COL_W'(1);
						end
					end
				end
			end
			REQ_CLEAR: begin
				walk_d = 1'b1;
			end
			REQ_SCROLL: begin
				if (in_lines >= 8'(ROWS)) begin
					status_d = 1'b1;
				end else if (in_lines != 8'd0) begin
					walk_d       = 1'b1;
					walk_lines_d = in_lines[ROW_W-1:0];
				end
			end
			REQ_CURSOR: begin
				if (!pos_ok) begin
					status_d = 1'b1;
				end else begin
					row_d = in_row[ROW_W-1:0];
					col_d = in_col[COL_W-1:0];
				end
			end
			REQ_READ: begin
				if (!pos_ok) begin
					status_d = 1'b1;
				end else begin
					read_d = 1'b1;
				end
			end
			default: begin
				status_d = 1'b1;
			end
		endcase
	end

	assign walk_cmd.start = accept && walk_d;
	assign walk_cmd.lines = walk_lines_d;

	ttw_screen #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_screen (
		.clk        (clk),
		.arst_n     (arst_n),
		.blank_cell (blank_cell),
		.wr_en      (accept && put_we),
		.wr_addr    (cursor_addr),
		.wr_data    (make_cell(in_char, fg_q, bg_q)),
		.rd_en      (accept && read_d),
		.rd_addr    (in_addr),
		.rd_data    (rd_data),
		.walk_cmd   (walk_cmd),
		.walk_done  (walk_done)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (read_d) begin
						state_d = ST_READ;
					end else if (walk_d) begin
						state_d = ST_WALK;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_WALK: begin
				if (walk_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			wrap_q      <= 1'b0;
			fg_q        <= FG_RESET;
			bg_q        <= BG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cur_row_q <= row_d;
				cur_col_q <= col_d;
				wrap_q    <= wrap_d;
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FG:  fg_q <= cfg_wdata;
					CFG_BG:  bg_q <= cfg_wdata;
					default: fg_q <= fg_q;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: built at accept, the read cell added in the read state.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.status     <= status_d;
			res_q.cursor_row <= row_d;
			res_q.cursor_col <= col_d;
			res_q.line_full  <= wrap_d;
			res_q.cell_word  <= '0;
		end else if (state_q == ST_READ) begin
			res_q.cell_word <= rd_data;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

	// The cursor never leaves the screen.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q < ROW_W'(ROWS)) && (cur_col_q < COL_W'(COLUMNS)))
		else $error("cursor outside the screen");

	// The sweeper finishes only while the control waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> (state_q == ST_WALK))
		else $error("sweep finished outside the walk state");

	// A started sweep holds the control in the walk state on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		walk_cmd.start |=> (state_q == ST_WALK) && !s_tready)
		else $error("sweep started without entering the walk state");

	// A result moves to the output only when the output register has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result overwritten");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the text-mode terminal writer.
`timescale 1ns / 1ps

module testbench;
	import ttw_pkg::*;

	localparam int COLS  = DEF_COLUMNS;
	localparam int ROWS  = DEF_ROWS;
	localparam int CELLS = COLS * ROWS;

	// Either side idles in about this many cycles out of a hundred.
	localparam int IDLE_PCT = 34;
	// Length of the long receiver hold-off that backs the block up into its input.
	localparam int HOLD_CYCLES = 400;
	// A stretch this long without a single beat on either side, far longer than a
	// full-screen sweep, means the block is stuck.
	localparam int STALL_LIMIT = 20000;
	// Cycles watched after the last result for stray result beats.
	localparam int SETTLE_CYCLES = 20;

	// Request kinds beyond the enum are illegal and must be rejected.
	localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Request beat. Packed members run from the top bit down, so the request kind
	// lands in the lowest bits, as on s_tdata.
	typedef struct packed {
		logic [7:0] column;
		logic [7:0] row;
		logic [7:0] lines;
		logic [7:0] code;
		logic [2:0] kind;
	} term_req_t;

	// Result beat, laid out the same way as the low bits of m_tdata.
	typedef struct packed {
		logic [CELL_W-1:0] cell_word;
		logic              line_full;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              status;
	} term_result_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	// req_type[2:0], char_code[10:3], scroll_lines[18:11], row[26:19], column[34:27]
	logic [39:0]      s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	// status[0], cursor_row[5:1], cursor_col[12:6], line_full[13], cell_word[29:14]
	logic [31:0]      m_tdata;
	logic             cfg_we    = 1'b0;
	logic [0:0]       cfg_index = CFG_FG;
	logic [CLR_W-1:0] cfg_wdata = '0;

	always #4 clk = ~clk;

	text_mode_terminal_writer #(
		.COLUMNS(COLS),
		.ROWS   (ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Our own picture of the terminal: screen, cursor, wrap flag and colors.
	logic [CELL_W-1:0] screen_model [CELLS];
	int                cur_row;
	int                cur_col;
	bit                wrapped;
	logic [CLR_W-1:0]  fg_model;
	logic [CLR_W-1:0]  bg_model;

	// Results predicted for accepted requests, oldest first.
	term_result_t awaited_results[$];

	int errors;
	int n_sent;
	int n_checked;
	int n_put;
	int n_newline;
	int n_clear;
	int n_scroll;
	int n_cursor;
	int n_read;
	int n_unknown;
	int n_rejected;
	int n_settings;
	int quiet_cycles;
	int hold_left;
	bit hold_request;
	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// A cell takes the colors that are current at the moment it is written.
	function automatic logic [CELL_W-1:0] colored_cell(input logic [7:0] code);
		return {bg_model, fg_model, code};
	endfunction

	function automatic void blank_from(input int first_row);
		for (int i = first_row * COLS; i < CELLS; i++)
			screen_model[i] = colored_cell(BLANK_CODE);
	endfunction

	// Rows move up by the given count and the rows freed at the bottom are blanked.
	function automatic void shift_up(input int lines);
		for (int i = 0; i < (ROWS - lines) * COLS; i++)
			screen_model[i] = screen_model[i + lines * COLS];
		blank_from(ROWS - lines);
	endfunction

	// Newline or wrap: column 0 of the next row, scrolling once past the bottom.
	function automatic void advance_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			shift_up(1);
			cur_row = ROWS - 1;
		end
	endfunction

	// Applies one request to the picture and returns the result the block owes for it.
	function automatic term_result_t run_terminal_request(input term_req_t r);
		term_result_t res;
		bool_pos_check: begin
		end
		res = '0;
		case (r.kind)
			REQ_PUT: begin
				n_put++;
				if (r.code == NEWLINE_CODE) begin
					n_newline++;
					// A newline right after a write that filled a line has already
					// been done by the wrap, so it only clears the flag.
					if (wrapped)
						wrapped = 1'b0;
					else
						advance_line();
				end else begin
					// Any other code clears the flag, even when it is rejected.
					wrapped = 1'b0;
					if (r.code < BLANK_CODE || r.code > LAST_PRINTABLE) begin
						res.status = STATUS_REJECT;
					end else begin
						screen_model[cur_row * COLS + cur_col] = colored_cell(r.code);
						cur_col++;
						if (cur_col >= COLS) begin
							wrapped = 1'b1;
							advance_line();
						end
					end
				end
			end
			REQ_CLEAR: begin
				n_clear++;
				blank_from(0);
			end
			REQ_SCROLL: begin
				n_scroll++;
				if (r.lines >= ROWS)
					res.status = STATUS_REJECT;
				else if (r.lines != 0)
					shift_up(r.lines);
			end
			REQ_CURSOR: begin
				n_cursor++;
				if (r.row >= ROWS || r.column >= COLS) begin
					res.status = STATUS_REJECT;
				end else begin
					cur_row = r.row;
					cur_col = r.column;
				end
			end
			REQ_READ: begin
				n_read++;
				if (r.row >= ROWS || r.column >= COLS)
					res.status = STATUS_REJECT;
				else
					res.cell_word = screen_model[r.row * COLS + r.column];
			end
			default: begin
				n_unknown++;
				res.status = STATUS_REJECT;
			end
		endcase
		if (res.status == STATUS_REJECT)
			n_rejected++;
		res.row       = cur_row[ROW_W-1:0];
		res.col       = cur_col[COL_W-1:0];
		res.line_full = wrapped;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result side: the receiver and the checker
	// ------------------------------------------------------------------

	// The receiver stalls at random, or not at all during the quiet stretch, and
	// holds off completely for HOLD_CYCLES when a test asks for it.
	always @(posedge clk) begin : result_sink
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !sink_idle_en || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Every result beat is compared with the oldest prediction, field by field.
	always @(posedge clk) begin : result_check
		term_result_t want;
		term_result_t got;
		if (m_tvalid && m_tready) begin
			got = term_result_t'(m_tdata[$bits(term_result_t)-1:0]);
			if (awaited_results.size() == 0) begin
				$display("%0t: result beat with no request outstanding, expected none, actual %h",
					$time, got);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				n_checked++;
				check_field("status", want.status, got.status);
				check_field("cursor_row", want.row, got.row);
				check_field("cursor_col", want.col, got.col);
				check_field("line_full", want.line_full, got.line_full);
				check_field("cell_word", want.cell_word, got.cell_word);
			end
		end
	end

	// Ends the run when neither side has moved a beat for far too long.
	always @(posedge clk) begin : stall_watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results still outstanding",
				$time, STALL_LIMIT, awaited_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one request, with a random gap first, and predicts its result once
	// the beat is taken. Valid stays high on return so back-to-back beats need
	// no second assignment in the same step.
	task automatic send_request(input term_req_t r);
		while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(40 - $bits(term_req_t)){1'b0}}, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		awaited_results.push_back(run_terminal_request(r));
		n_sent++;
	endtask

	// The sender stops and waits until every predicted result has come back.
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Both color registers are written back to back, only while the block is idle.
	task automatic set_colors(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
		wait_all_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FG;
		cfg_wdata <= fg;
		@(posedge clk);
		cfg_index <= CFG_BG;
		cfg_wdata <= bg;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		fg_model = fg;
		bg_model = bg;
		n_settings++;
	endtask

	function automatic term_req_t make_req(input logic [2:0] kind, input logic [7:0] code,
		input logic [7:0] lines, input logic [7:0] row, input logic [7:0] column);
		term_req_t r;
		r.kind   = kind;
		r.code   = code;
		r.lines  = lines;
		r.row    = row;
		r.column = column;
		return r;
	endfunction

	// Mostly printable text with cursor moves and reads of the screen; newlines,
	// clears and scrolls stay rare because each can sweep the whole screen. Fields a
	// request ignores keep random values so every bit toggles.
	function automatic term_req_t random_request();
		term_req_t r;
		int        pick;
		r    = term_req_t'($bits(term_req_t)'({$urandom, $urandom}));
		pick = $urandom_range(99);
		if (pick < 58) begin
			r.kind = REQ_PUT;
			pick   = $urandom_range(99);
			if (pick < 82)
				r.code = 8'($urandom_range(LAST_PRINTABLE, BLANK_CODE));
			else if (pick < 86)
				r.code = NEWLINE_CODE;
		end else if (pick < 86) begin
			r.kind = (pick < 68) ? REQ_CURSOR : REQ_READ;
			if ($urandom_range(99) < 85) begin
				r.row    = 8'($urandom_range(ROWS - 1));
				r.column = 8'($urandom_range(COLS - 1));
			end
		end else if (pick < 88) begin
			r.kind = REQ_CLEAR;
		end else if (pick < 92) begin
			r.kind = REQ_SCROLL;
			if ($urandom_range(99) < 60)
				r.lines = 8'($urandom_range(ROWS - 1, 1));
		end else begin
			r.kind = 3'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST));
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Boundaries and every special case, in reset colors. The screen is cleared
	// first so that no read ever touches a cell that was never written.
	task automatic test_directed();
		send_request(make_req(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, 8'h41, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, BLANK_CODE, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, LAST_PRINTABLE, 8'h00, 8'h00, 8'h00));
		// Codes just below the printable range and at the top of the byte.
		send_request(make_req(REQ_PUT, BLANK_CODE - 8'd1, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_request(make_req(REQ_PUT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00));
		// The last cell of the screen: the write wraps and scrolls one line, and
		// the newline that follows is swallowed; a second one scrolls again.
		send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'(ROWS - 1), 8'(COLS - 1)));
		send_request(make_req(REQ_PUT, 8'h5A, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00));
		// A wrap at the top without a scroll; a rejected code then clears the
		// flag, so the next newline really advances.
		send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'h00, 8'(COLS - 1)));
		send_request(make_req(REQ_PUT, LAST_PRINTABLE, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, 8'h00, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_PUT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00));
		// Positions off the screen.
		send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'hFF, 8'hFF));
		send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'(ROWS), 8'h00));
		send_request(make_req(REQ_READ, 8'h00, 8'h00, 8'h00, 8'(COLS)));
		// The character written into the last cell, two scrolls further up.
		send_request(make_req(REQ_READ, 8'h00, 8'h00, 8'(ROWS - 3), 8'(COLS - 1)));
		send_request(make_req(REQ_SCROLL, 8'h00, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_SCROLL, 8'h00, 8'(ROWS - 1), 8'h00, 8'h00));
		send_request(make_req(REQ_SCROLL, 8'h00, 8'(ROWS), 8'h00, 8'h00));
		send_request(make_req(REQ_UNKNOWN_LAST, 8'h00, 8'h00, 8'h00, 8'h00));
		send_request(make_req(REQ_UNKNOWN_FIRST, 8'h00, 8'h00, 8'h00, 8'h00));
	endtask

	// Color settings, the extremes among them; each phase clears the screen in the
	// new colors and then writes, scrolls and reads in them.
	task automatic test_colors();
		logic [CLR_W-1:0] fg_list [5];
		logic [CLR_W-1:0] bg_list [5];
		fg_list = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd0};
		bg_list = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd0};
		fg_list[4] = CLR_W'($urandom_range(15));
		bg_list[4] = CLR_W'($urandom_range(15));
		for (int s = 0; s < 5; s++) begin
			set_colors(fg_list[s], bg_list[s]);
			send_request(make_req(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
			repeat (80)
				send_request(random_request());
		end
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so
	// the block fills up and stops taking them; then the sender waits it out.
	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (30)
			send_request(random_request());
		wait_all_results();
	endtask

	// Bulk random traffic: first a stretch at full rate on both sides, then with
	// random gaps and stalls on both.
	task automatic test_random();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		repeat (300)
			send_request(random_request());
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (1050)
			send_request(random_request());
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = '0;
		cur_row  = 0;
		cur_col  = 0;
		wrapped  = 1'b0;
		fg_model = FG_RESET;
		bg_model = BG_RESET;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_colors();
		test_backpressure();
		test_random();

		wait_all_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("Ran %0d requests through %0d color settings, %0d results checked.",
			n_sent, n_settings + 1, n_checked);
		$display("Mix: %0d puts (%0d newlines), %0d clears, %0d scrolls, %0d moves,",
			n_put, n_newline, n_clear, n_scroll, n_cursor);
		$display("     %0d reads, %0d illegal; %0d rejected.",
			n_read, n_unknown, n_rejected);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
rtl/core/ttw_pkg.sv
rtl/core/ttw_screen.sv
rtl/core/text_mode_terminal_writer.sv
tb/sv/testbench.sv
